// ----- design/sha_pkg.sv -----
// Package for the SHA-256 stream hasher: round constants, initial hash values,
// queue entry type and the round helper functions. No dependencies.
package sha_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } sha_item_t;

    localparam int QueueDepth = 4;

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                3'd0: r = 32'h6A09E667;
                3'd1: r = 32'hBB67AE85;
                3'd2: r = 32'h3C6EF372;
                3'd3: r = 32'hA54FF53A;
                3'd4: r = 32'h510E527F;
                3'd5: r = 32'h9B05688C;
                3'd6: r = 32'h1F83D9AB;
                default: r = 32'h5BE0CD19;
            endcase
            return r;
        end
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- design/sha_if.sv -----
// Valid/ready channel interfaces for the hasher's input and digest output.
// Depends on nothing.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    modport source (output valid, output action, output data_byte, input ready);
    modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

// ----- design/sha256_stream_hasher.sv -----
// Top level of the SHA-256 stream hasher: input queue feeding the hash core.
// Depends on sha_pkg, sha_if, sha_queue and sha_core.
//
//  channel   dir   payload
//  in_ch     in    action, data_byte
//  out_ch    out   digest_word, word_index, last_word
//
// An absorb word goes into the block buffer; one that fills a block starts compression.
// A finish word takes the padding bytes at one a cycle, then compresses each block
// (one or two), then eight digest words, one per cycle while out_ch is ready.
// The 64-round compression loop sets the rate; the queue absorbs input meanwhile.
// Reset restores the initial hash values and empties the queue.
module sha256_stream_hasher (
    input  logic clk,
    input  logic rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    import sha_pkg::*;

    sha_item_t in_item;
    sha_item_t q_item;
    logic      q_valid;
    logic      q_ready;

    assign in_item.action    = in_ch.action;
    assign in_item.data_byte = in_ch.data_byte;

    sha_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    sha_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (q_valid),
        .item_ready  (q_ready),
        .item        (q_item),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .digest_word (out_ch.digest_word),
        .word_index  (out_ch.word_index),
        .last_word   (out_ch.last_word)
    );
endmodule

// ----- design/sha_queue.sv -----
// Front part: accepts input words into a short queue between front and back.
// Depends on sha_pkg.
module sha_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sha_pkg::sha_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output sha_pkg::sha_item_t out_item
);
    import sha_pkg::*;

    localparam int AW = $clog2(QueueDepth);

    sha_item_t        mem_reg [QueueDepth];
    logic [AW-1:0]    wr_reg;
    logic [AW-1:0]    rd_reg;
    logic [AW:0]      cnt_reg;
    logic             push;
    logic             pop;

    assign in_ready  = cnt_reg < (AW+1)'(QueueDepth);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ----- design/sha_core.sv -----
// Back part: block buffer, padding sequencer, one-round-per-cycle compression
// and digest output register. Depends on sha_pkg.
module sha_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  sha_pkg::sha_item_t item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       digest_word,
    output logic [2:0]        word_index,
    output logic              last_word
);
    import sha_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]  state_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [63:0] len_reg;
    logic        fin_reg;
    logic        pad_len_reg;
    logic [5:0]  round_reg;
    logic [2:0]  emit_reg;

    logic        push;
    logic [7:0]  push_byte;
    logic [7:0]  pad_byte;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] wnew;
    logic [31:0] s0;
    logic [31:0] s1;

    assign item_ready  = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_EMIT);
    assign digest_word = h_reg[emit_reg];
    assign word_index  = emit_reg;
    assign last_word   = (emit_reg == 3'd7);

    always_comb
    begin
        if (fill_reg >= 6'd56 && pad_len_reg)
        begin
            pad_byte = len_reg[8*(63-fill_reg) +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + ROUND_K[round_reg] + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb
    begin
        push      = 1'b0;
        push_byte = 8'h00;
        if (state_reg == ST_IDLE && item_valid)
        begin
            push      = 1'b1;
            push_byte = item.action ? 8'h80 : item.data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            push      = 1'b1;
            push_byte = pad_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            w_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= push_byte;
        end
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wnew;
            for (int i = 1; i < 8; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            v_reg[4] <= v_reg[3] + t1;
            v_reg[0] <= t1 + t2;
        end
        else if (push && fill_reg == 6'd63)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        if (state_reg == ST_IDLE && item_valid && item.action)
        begin
            len_reg <= bits_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            bits_reg    <= '0;
            fin_reg     <= 1'b0;
            pad_len_reg <= 1'b0;
            round_reg   <= '0;
            emit_reg    <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_h(3'(i));
            end
        end
        else
        begin
            if (push)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        if (item.action)
                        begin
                            fin_reg     <= 1'b1;
                            pad_len_reg <= (fill_reg < 6'd56);
                        end
                        else
                        begin
                            bits_reg <= bits_reg + 64'd8;
                        end
                        if (fill_reg == 6'd63)
                        begin
                            state_reg <= ST_ROUND;
                            round_reg <= '0;
                        end
                        else if (item.action)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    if (fill_reg == 6'd63)
                    begin
                        state_reg <= ST_ROUND;
                        round_reg <= '0;
                    end
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (!fin_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (pad_len_reg)
                    begin
                        state_reg <= ST_EMIT;
                        emit_reg  <= '0;
                    end
                    else
                    begin
                        pad_len_reg <= 1'b1;
                        state_reg   <= ST_PAD;
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        emit_reg <= emit_reg + 1'b1;
                        if (emit_reg == 3'd7)
                        begin
                            state_reg <= ST_IDLE;
                            fin_reg   <= 1'b0;
                            bits_reg  <= '0;
                            fill_reg  <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= init_h(3'(i));
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- design/sha_checker.sv -----
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_stream_hasher.
module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match word_index");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word))
        else $error("stalled digest word changed");

    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=> out_valid
            && word_index == $past(word_index) + 3'd1)
        else $error("digest words not consecutive");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> !out_valid)
        else $error("digest continued past last word");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .digest_word (out_ch.digest_word),
    .word_index  (out_ch.word_index),
    .last_word   (out_ch.last_word)
);

// ----- tb/sv/sha_digest_checker.sv -----
`timescale 1ns / 1ps
// Checker for the SHA-256 stream hasher: computes digests from accepted input words
// and compares every digest word. Depends on nothing.
module sha_digest_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       in_action,
    input  logic [7:0] in_data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] out_digest_word,
    input  logic [2:0]  out_word_index,
    input  logic        out_last_word,
    output int          fail_count,
    output int          pending_words,
    output int          digest_count
);
    localparam logic [31:0] IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };
    localparam logic [31:0] KTAB [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic [31:0] chain [8];
    logic [7:0]  block [64];
    int unsigned fill;
    logic [63:0] msg_bits;
    digest_word_t digest_q [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        v = chain;
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endtask

    task automatic append_byte(input logic [7:0] b);
        block[fill] = b;
        fill++;
        if (fill == 64)
        begin
            compress();
            fill = 0;
        end
    endtask

    task automatic restart();
        chain = IV;
        fill = 0;
        msg_bits = '0;
    endtask

    task automatic finish_message();
        logic [63:0] len;
        digest_word_t d;
        len = msg_bits;
        append_byte(8'h80);
        while (fill != 56)
            append_byte(8'h00);
        for (int i = 0; i < 8; i++)
            append_byte(len[63-8*i -: 8]);
        for (int i = 0; i < 8; i++)
        begin
            d.word = chain[i];
            d.index = 3'(i);
            d.last = (i == 7);
            digest_q.push_back(d);
        end
        restart();
    endtask

    assign pending_words = digest_q.size();

    initial
    begin
        fail_count = 0;
        digest_count = 0;
        restart();
    end

    always @(posedge clk)
    begin
        digest_word_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t: unexpected digest word %h index %0d",
                             $time, out_digest_word, out_word_index);
                    fail_count++;
                end
                else
                begin
                    e = digest_q.pop_front();
                    if (e.last)
                        digest_count++;
                    if (out_digest_word !== e.word || out_word_index !== e.index
                        || out_last_word !== e.last)
                    begin
                        $display("%0t: mismatch expected %h/%0d/%b actual %h/%0d/%b",
                                 $time, e.word, e.index, e.last,
                                 out_digest_word, out_word_index, out_last_word);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_action)
                    finish_message();
                else
                begin
                    msg_bits += 64'd8;
                    append_byte(in_data_byte);
                end
            end
        end
    end
endmodule

// ----- tb/sv/tb_sha256_stream_hasher.sv -----
`timescale 1ns / 1ps
// Testbench top for sha256_stream_hasher: drives messages with bursty input and a
// stalling receiver, and reports the verdict. Depends on sha_if and sha_digest_checker.
module tb_sha256_stream_hasher;
    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;
    localparam int IdleLimit = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_words;
    int   digest_count;
    int   idle_cycles;
    int   words_sent;
    bit   hold_off;
    bit   stim_done;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_stream_hasher i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    sha_digest_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .in_action       (in_ch.action),
        .in_data_byte    (in_ch.data_byte),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_digest_word (out_ch.digest_word),
        .out_word_index  (out_ch.word_index),
        .out_last_word   (out_ch.last_word),
        .fail_count      (fail_count),
        .pending_words   (pending_words),
        .digest_count    (digest_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    int burst_left;

    task automatic send_word(input logic act, input logic [7:0] b);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_message(input int len, input bit random_data);
        for (int i = 0; i < len; i++)
            send_word(ACT_ABSORB, random_data ? 8'($urandom) : 8'(i));
        send_word(ACT_FINISH, 8'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_ABSORB;
        in_ch.data_byte = 8'h00;
        burst_left = 0;
        words_sent = 0;
        stim_done = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        send_word(ACT_FINISH, 8'hFF);
        send_word(ACT_ABSORB, 8'h00);
        send_word(ACT_ABSORB, 8'hFF);
        send_word(ACT_ABSORB, 8'hA5);
        send_word(ACT_FINISH, 8'h00);
        send_word(ACT_ABSORB, 8'h5A);
        send_word(ACT_FINISH, 8'h5A);
        send_word(ACT_FINISH, 8'h80);
        send_message(55, 1'b1);
        send_message(56, 1'b1);
        send_message(64, 1'b1);
        while (words_sent < 205)
        begin
            case ($urandom_range(0, 5))
                0: send_message($urandom_range(0, 3), 1'b1);
                1: send_message($urandom_range(54, 57), 1'b1);
                2: send_message($urandom_range(62, 66), 1'b0);
                3: send_word(ACT_FINISH, 8'($urandom));
                default: send_message($urandom_range(0, 20), 1'b1);
            endcase
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        hold_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_off && digest_count == 3)
            begin
                hold_off = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            if ((words_sent / 60) % 2 == 0)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        idle_cycles = 0;
        wait (stim_done && pending_words == 0 || idle_cycles >= IdleLimit);
        if (idle_cycles >= IdleLimit)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("sha256_stream_hasher test failed");
            $finish;
        end
        else
        begin
            repeat (200) @(posedge clk);
            $display("Ran %0d input words and checked %0d digests, with padding edges,",
                     words_sent, digest_count);
            $display("block boundaries, empty messages and a long output stall.");
            if (fail_count == 0)
                $display("sha256_stream_hasher test passed");
            else
                $display("sha256_stream_hasher test failed");
            $finish;
        end
    end
endmodule

// ----- files.f -----
design/sha_pkg.sv
design/sha_if.sv
design/sha_queue.sv
design/sha_core.sv
design/sha256_stream_hasher.sv
design/sha_checker.sv
tb/sv/sha_digest_checker.sv
tb/sv/tb_sha256_stream_hasher.sv
